>>> rtl/core/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types, constants and color helper for the thermal false-color mapper.
// ----------------------------------------------------------------------------
package tpm_pkg;

  // temperature word and hue span
  localparam int TEMP_BITS = 16;
  localparam int HUE_SPAN  = 240;

  // hue width and divider layout
  localparam int HUE_W           = $clog2(HUE_SPAN + 1);
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (HUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int QW              = DIV_STAGES * STEPS_PER_STAGE;
  localparam int NUM_W           = TEMP_BITS + HUE_W;

  // stream widths
  localparam int RGB_W        = 16;
  localparam int HUE_OUT_W    = 8;
  localparam int IN_TDATA_W   = ((TEMP_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RGB_W + HUE_OUT_W + TEMP_BITS + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // configuration registers
  localparam int CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_TEMP = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TEMP = CFG_ADDR_W'(1);
  localparam logic signed [TEMP_BITS-1:0] MIN_TEMP_RST = TEMP_BITS'(320);
  localparam logic signed [TEMP_BITS-1:0] MAX_TEMP_RST = TEMP_BITS'(640);

  // color sector geometry: 255/60 reduces to 17/4
  localparam int SECTOR_DEG = 60;
  localparam int NUM_SECTORS = 6;
  localparam logic [9:0] RAMP_MUL = 10'd17;

  // per-item side data carried down the pipe
  typedef struct packed {
    logic signed [TEMP_BITS-1:0] temp;
    logic                        err;
  } side_t;

  // divider working set
  typedef struct packed {
    side_t                side;
    logic [TEMP_BITS-1:0] den;
    logic [TEMP_BITS-1:0] rem;
    logic [QW-1:0]        qr;
  } div_t;

  // result beat
  typedef struct packed {
    logic [RGB_W-1:0]            rgb565;
    logic [HUE_OUT_W-1:0]        hue;
    logic signed [TEMP_BITS-1:0] temp;
    logic                        err;
  } res_t;

  // hue to rgb565 at full saturation and value
  function automatic logic [RGB_W-1:0] hue_to_rgb565(input logic [HUE_W-1:0] hue);
    logic [2:0] sector;
    logic [5:0] m;
    logic [9:0] up_x;
    logic [9:0] dn_x;
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    sector = 3'd0;
    for (int i = 1; i < NUM_SECTORS; i++) begin
      if (int'(hue) >= SECTOR_DEG * i) begin
        sector = 3'(i);
      end
    end
    m    = 6'(int'(hue) - SECTOR_DEG * int'(sector));
    up_x = 10'(m) * RAMP_MUL;
    dn_x = 10'(7'(SECTOR_DEG) - 7'(m)) * RAMP_MUL;
    up   = up_x[9:2];
    dn   = dn_x[9:2];
    case (sector)
      3'd0: begin r = 8'hFF; g = up;    b = 8'h00; end
      3'd1: begin r = dn;    g = 8'hFF; b = 8'h00; end
      3'd2: begin r = 8'h00; g = 8'hFF; b = up;    end
      3'd3: begin r = 8'h00; g = dn;    b = 8'hFF; end
      3'd4: begin r = up;    g = 8'h00; b = 8'hFF; end
      default: begin r = 8'hFF; g = 8'h00; b = dn; end
    endcase
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> rtl/core/thermal_pseudocolor_map.sv
// ----------------------------------------------------------------------------
// thermal_pseudocolor_map
// Maps signed pixel temperatures to a false-color rgb565 pixel, blue for cold
// and red for hot, through a clamp, a pipelined divider and a hue converter.
//
//   channel   direction  signals                        beat
//   s_axis    in         tvalid tready tdata[15:0]      one temperature
//   m_axis    out        tvalid tready tdata[47:0]      one color result
//   cfg       in         valid ready addr[7:0] wdata    one register write
//
// one beat accepted per cycle unless m_axis stalls; stages are two front
// stages, four divider stages (two quotient bits each) and two color stages
// the divider depth follows the hue width, so the divider sets the latency
// reset clears every stage valid bit and loads min 320, max 640
// each stage takes a beat when empty or when its successor moves, so a
// stall on m_axis fills bubbles first and then holds every stage
// ----------------------------------------------------------------------------
module thermal_pseudocolor_map (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // temperature in, bits [15:0] temperature
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [tpm_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  // result out, [15:0] rgb565, [23:16] hue, [39:24] clamped_temperature,
  // [40] range_error, rest zero
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [tpm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tpm_pkg::CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [tpm_pkg::TEMP_BITS-1:0]          cfg_wdata_i
);
  import tpm_pkg::*;

  logic signed [TEMP_BITS-1:0] min_temp_q;
  logic signed [TEMP_BITS-1:0] max_temp_q;
  logic [DIV_STAGES:0]         div_valid;
  logic [DIV_STAGES:0]         div_ready;
  div_t                        div_data [DIV_STAGES+1];
  res_t                        res;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_temp_q <= MIN_TEMP_RST;
      max_temp_q <= MAX_TEMP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_MIN_TEMP: min_temp_q <= cfg_wdata_i;
        REG_MAX_TEMP: max_temp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp and scale
  tpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_temp_i  (min_temp_q),
    .max_temp_i  (max_temp_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .temp_i      (signed'(s_axis_tdata[TEMP_BITS-1:0])),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_o       (div_data[0])
  );

  // divider chain
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    tpm_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[k]),
      .in_ready_o  (div_ready[k]),
      .in_i        (div_data[k]),
      .out_valid_o (div_valid[k+1]),
      .out_ready_i (div_ready[k+1]),
      .out_o       (div_data[k+1])
    );
  end

  // hue and color
  tpm_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[DIV_STAGES]),
    .in_ready_o  (div_ready[DIV_STAGES]),
    .in_i        (div_data[DIV_STAGES]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // pack result beat
  assign m_axis_tdata = OUT_TDATA_W'({res.err, res.temp, res.hue, res.rgb565});

`ifndef NO_ASSERTIONS
  // input backpressure only arises when the output holds a beat
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output stage");

  // a bad range gives the full-span hue and its color
  a_error_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.err) |->
      (res.hue == HUE_OUT_W'(HUE_SPAN)) &&
      (res.rgb565 == hue_to_rgb565(HUE_W'(HUE_SPAN))))
    else $error("range error beat without full-span hue");
`endif

endmodule

>>> rtl/core/tpm_front.sv
// ----------------------------------------------------------------------------
// tpm_front
// Clamp stage and scale stage: clamps the temperature, forms t-min and
// max-min, multiplies by the hue span and seeds the divider.
// ----------------------------------------------------------------------------
module tpm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [tpm_pkg::TEMP_BITS-1:0] min_temp_i,
  input  logic signed [tpm_pkg::TEMP_BITS-1:0] max_temp_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [tpm_pkg::TEMP_BITS-1:0] temp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tpm_pkg::div_t                  out_o
);
  import tpm_pkg::*;

  logic                 a_valid_q;
  side_t                a_side_q;
  logic [TEMP_BITS-1:0] a_diff_q;
  logic [TEMP_BITS-1:0] a_den_q;
  logic                 b_valid_q;
  div_t                 b_q;
  logic                 a_ready;
  logic                 b_ready;
  logic signed [TEMP_BITS-1:0] clamp_d;
  side_t                side_d;
  logic [NUM_W-1:0]     num;
  div_t                 b_d;

  // stage handshake, bubbles fill
  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // clamp and range check
  always_comb begin
    if (temp_i < min_temp_i) begin
      clamp_d = min_temp_i;
    end else if (temp_i > max_temp_i) begin
      clamp_d = max_temp_i;
    end else begin
      clamp_d = temp_i;
    end
    side_d.temp = clamp_d;
    side_d.err  = (max_temp_i <= min_temp_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_side_q <= side_d;
      a_diff_q <= TEMP_BITS'(clamp_d - min_temp_i);
      a_den_q  <= TEMP_BITS'(max_temp_i - min_temp_i);
    end
  end

  // scale by hue span; numerator top bits are already below the divisor
  always_comb begin
    num     = NUM_W'(a_diff_q) * NUM_W'(HUE_SPAN);
    b_d.side = a_side_q;
    b_d.den  = a_den_q;
    b_d.rem  = TEMP_BITS'(num >> QW);
    b_d.qr   = num[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

>>> rtl/core/tpm_div_stage.sv
// ----------------------------------------------------------------------------
// tpm_div_stage
// One register stage of the restoring divider: a fixed number of
// shift-compare-subtract steps, quotient bits shifted in from the bottom.
// ----------------------------------------------------------------------------
module tpm_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpm_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tpm_pkg::div_t out_o
);
  import tpm_pkg::*;

  logic               valid_q;
  div_t               data_q;
  div_t               data_d;
  logic [TEMP_BITS:0] trial;
  logic               take;

  assign in_ready_o = !valid_q || out_ready_i;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    data_d = in_i;
    trial  = '0;
    take   = 1'b0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial      = {data_d.rem, data_d.qr[QW-1]};
      take       = (trial >= {1'b0, data_d.den});
      data_d.rem = take ? TEMP_BITS'(trial - {1'b0, data_d.den}) : trial[TEMP_BITS-1:0];
      data_d.qr  = {data_d.qr[QW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

>>> rtl/core/tpm_color.sv
// ----------------------------------------------------------------------------
// tpm_color
// Hue stage and color stage: rounds the quotient up, forms the hue, then
// converts it to rgb565 in the output register.
// ----------------------------------------------------------------------------
module tpm_color (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpm_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tpm_pkg::res_t out_o
);
  import tpm_pkg::*;

  localparam logic [QW:0] SPAN_Q = (QW + 1)'(HUE_SPAN);

  logic             h_valid_q;
  logic [HUE_W-1:0] h_hue_q;
  side_t            h_side_q;
  logic             c_valid_q;
  res_t             c_q;
  logic             h_ready;
  logic             c_ready;
  logic [QW:0]      ceil_q;
  logic [HUE_W-1:0] hue_d;
  res_t             c_d;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign h_ready    = !h_valid_q || c_ready;
  assign in_ready_o = h_ready;

  // ceiling of the quotient, hue counts down from the span
  always_comb begin
    ceil_q = (QW + 1)'(in_i.qr) + (QW + 1)'(in_i.rem != '0);
    hue_d  = in_i.side.err ? HUE_W'(HUE_SPAN) : HUE_W'(SPAN_Q - ceil_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (h_ready) begin
      h_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_ready && in_valid_i) begin
      h_hue_q  <= hue_d;
      h_side_q <= in_i.side;
    end
  end

  // sector ramps and 565 packing
  always_comb begin
    c_d.rgb565 = hue_to_rgb565(h_hue_q);
    c_d.hue    = HUE_OUT_W'(h_hue_q);
    c_d.temp   = h_side_q.temp;
    c_d.err    = h_side_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && h_valid_q) begin
      c_q <= c_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_o       = c_q;

endmodule

>>> bench/thermal_pseudocolor_map_checker.sv
// ----------------------------------------------------------------------------
// thermal_pseudocolor_map_checker
// Watches the temperature, result and register channels of the false-color
// mapper. It keeps its own copy of the clamp range, predicts the color beat
// for every accepted temperature and compares each result beat, field by
// field, with the oldest prediction. Failures are counted for the top.
// ----------------------------------------------------------------------------
module thermal_pseudocolor_map_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [tpm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [tpm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [tpm_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [tpm_pkg::TEMP_BITS-1:0]      cfg_wdata_i,
  output int unsigned                        pending_o,
  output int unsigned                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tpm_pkg::*;

  localparam int DEG_PER_SECTOR = 60;
  localparam int FULL_SCALE     = 255;
  localparam int MAX_REPORTS    = 10;

  // range as the block should hold it
  logic signed [TEMP_BITS-1:0] range_lo;
  logic signed [TEMP_BITS-1:0] range_hi;

  // predicted color beats, oldest first
  res_t        pixel_q[$];
  int unsigned fails;

  // clamp, scale to hue, then hue to rgb565 with exact integer math
  function automatic res_t predict_pixel(input logic signed [TEMP_BITS-1:0] temp,
                                         input logic signed [TEMP_BITS-1:0] lo,
                                         input logic signed [TEMP_BITS-1:0] hi);
    res_t       px;
    int         t;
    int         l;
    int         h;
    longint     num;
    longint     den;
    longint     steps;
    int         hue;
    int         m;
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    t = temp;
    l = lo;
    h = hi;
    if (t < l) begin
      t = l;
    end else if (t > h) begin
      t = h;
    end
    // an empty or inverted range flags an error and falls back to blue
    if (h <= l) begin
      px.err = 1'b1;
      hue    = HUE_SPAN;
    end else begin
      num    = longint'(t - l) * HUE_SPAN;
      den    = longint'(h - l);
      steps  = (num + den - 1) / den;
      px.err = 1'b0;
      hue    = HUE_SPAN - int'(steps);
    end
    m  = hue % DEG_PER_SECTOR;
    up = 8'((m * FULL_SCALE) / DEG_PER_SECTOR);
    dn = 8'(((DEG_PER_SECTOR - m) * FULL_SCALE) / DEG_PER_SECTOR);
    case (hue / DEG_PER_SECTOR)
      0: begin r = 8'hFF; g = up;    b = 8'h00; end
      1: begin r = dn;    g = 8'hFF; b = 8'h00; end
      2: begin r = 8'h00; g = 8'hFF; b = up;    end
      3: begin r = 8'h00; g = dn;    b = 8'hFF; end
      4: begin r = up;    g = 8'h00; b = 8'hFF; end
      default: begin r = 8'hFF; g = 8'h00; b = dn; end
    endcase
    px.rgb565 = {r[7:3], g[7:2], b[7:3]};
    px.hue    = 8'(hue);
    px.temp   = TEMP_BITS'(t);
    return px;
  endfunction

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // monitor all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t       got;
    res_t       want;
    logic [6:0] pad;
    if (!rst_ni) begin
      range_lo = MIN_TEMP_RST;
      range_hi = MAX_TEMP_RST;
      pixel_q.delete();
      fails    = 0;
    end else begin
      // result beat against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.rgb565 = m_axis_tdata[15:0];
        got.hue    = m_axis_tdata[23:16];
        got.temp   = m_axis_tdata[39:24];
        got.err    = m_axis_tdata[40];
        pad        = m_axis_tdata[47:41];
        if (pixel_q.size() == 0) begin
          note_failure($sformatf("result beat with none pending, tdata %h", m_axis_tdata));
        end else begin
          want = pixel_q.pop_front();
          if (got != want || pad != '0) begin
            note_failure($sformatf(
              "rgb565 %h/%h hue %0d/%0d temp %0d/%0d err %0b/%0b pad %h (exp/act)",
              want.rgb565, got.rgb565, want.hue, got.hue, want.temp, got.temp,
              want.err, got.err, pad));
          end
        end
      end
      // temperature beat uses the range in force when it is taken
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_q.push_back(predict_pixel(s_axis_tdata[TEMP_BITS-1:0], range_lo, range_hi));
      end
      // register write, other indexes are ignored
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == REG_MIN_TEMP) begin
          range_lo = cfg_wdata_i;
        end else if (cfg_addr_i == REG_MAX_TEMP) begin
          range_hi = cfg_wdata_i;
        end
      end
    end
    pending_o    <= pixel_q.size();
    fail_count_o <= fails;
  end

endmodule

>>> bench/thermal_pseudocolor_map_tb.sv
// ----------------------------------------------------------------------------
// thermal_pseudocolor_map_tb
// Drives temperatures and register writes into the false-color mapper with
// random gaps and output stalls, over many clamp ranges including the full,
// empty and inverted ones. A checker beside the block predicts and compares
// every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module thermal_pseudocolor_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpm_pkg::*;

  localparam int                    TOTAL_TEMPS      = 1600;
  localparam int                    CALM_AFTER       = 1350;
  localparam int                    WATCHDOG_LIMIT   = 2000;
  localparam int                    TAIL_CYCLES      = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_UNUSED = CFG_ADDR_W'(2);
  localparam int                    REG_LAST         = (1 << CFG_ADDR_W) - 1;
  localparam int                    TEMP_MIN         = -32768;
  localparam int                    TEMP_MAX         = 32767;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]      m_axis_tdata;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_ADDR_W-1:0]       cfg_addr_i = '0;
  logic [TEMP_BITS-1:0]        cfg_wdata_i = '0;
  int unsigned                 pending;
  int unsigned                 fail_count;
  bit                          gaps_on = 1'b1;
  int                          cur_lo = 320;
  int                          cur_hi = 640;

  thermal_pseudocolor_map u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  thermal_pseudocolor_map_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result side stalls in short bursts
  initial begin : stall_gen
    int n;
    @(posedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      n = $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (n) @(posedge clk_i);
    end
  end

  // end the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("thermal_pseudocolor_map_tb: FAIL");
        $finish;
      end
    end
  end

  // one temperature beat, optionally after a short gap
  task automatic send_temp(input int temp);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom);
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(temp);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and let every pending color beat come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one register write beat, valid is lowered by the caller
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input int value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= TEMP_BITS'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (addr == REG_MIN_TEMP) begin
      cur_lo = value;
    end else if (addr == REG_MAX_TEMP) begin
      cur_hi = value;
    end
  endtask

  task automatic set_range(input int lo, input int hi);
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      reg_write(REG_MIN_TEMP, lo);
      reg_write(REG_MAX_TEMP, hi);
    end else begin
      reg_write(REG_MAX_TEMP, hi);
      reg_write(REG_MIN_TEMP, lo);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int lo;
    int hi;
    int a;
    int b;
    int t;
    int n;
    int choice;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset range: extremes, clamp edges and the sector boundaries
    send_temp(TEMP_MIN);
    send_temp(TEMP_MAX);
    send_temp(0);
    send_temp(-1);
    send_temp(319);
    send_temp(320);
    send_temp(321);
    send_temp(400);
    send_temp(401);
    send_temp(480);
    send_temp(560);
    send_temp(639);
    send_temp(640);
    send_temp(641);
    send_temp(16'h5555);
    send_temp(16'hAAAA);

    // widest range
    set_range(TEMP_MIN, TEMP_MAX);
    send_temp(TEMP_MIN);
    send_temp(TEMP_MAX);
    send_temp(0);

    // a write to an unused index must leave the range alone
    wait_idle();
    reg_write(REG_FIRST_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
    send_temp(-12345);

    // empty range, then inverted range
    set_range(100, 100);
    send_temp(99);
    send_temp(100);
    send_temp(101);
    set_range(TEMP_MAX, TEMP_MIN);
    send_temp(0);
    send_temp(TEMP_MAX);

    // random ranges, each followed by a batch of temperatures
    sent = 0;
    while (sent < TOTAL_TEMPS) begin
      if (sent >= CALM_AFTER) begin
        gaps_on = 1'b0;
      end
      choice = $urandom_range(0, 7);
      case (choice)
        0: begin lo = 320; hi = 640; end
        1: begin lo = TEMP_MIN; hi = TEMP_MAX; end
        2: begin
          lo = int'($urandom_range(0, 65534)) + TEMP_MIN;
          hi = lo + int'($urandom_range(1, TEMP_MAX - lo));
        end
        3: begin
          lo = int'($urandom_range(0, 65531)) + TEMP_MIN;
          hi = lo + int'($urandom_range(1, 4));
        end
        4: begin
          lo = int'($urandom_range(0, 65535)) + TEMP_MIN;
          hi = lo;
        end
        5: begin
          hi = int'($urandom_range(0, 65534)) + TEMP_MIN;
          lo = hi + int'($urandom_range(1, TEMP_MAX - hi));
        end
        6: begin
          lo = int'($urandom_range(0, 65535)) + TEMP_MIN;
          hi = int'($urandom_range(0, 65535)) + TEMP_MIN;
        end
        default: begin
          lo = int'($urandom_range(0, 60000)) + TEMP_MIN;
          hi = lo + int'($urandom_range(1, 300));
        end
      endcase
      // now and then touch one register only, or an unused index too
      n = $urandom_range(0, 5);
      if (n == 0) begin
        wait_idle();
        reg_write(REG_MIN_TEMP, lo);
        cfg_valid_i <= 1'b0;
      end else if (n == 1) begin
        wait_idle();
        reg_write(CFG_ADDR_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST)), $urandom);
        reg_write(REG_MAX_TEMP, hi);
        cfg_valid_i <= 1'b0;
      end else begin
        set_range(lo, hi);
      end

      a = (cur_lo < cur_hi) ? cur_lo : cur_hi;
      b = (cur_lo < cur_hi) ? cur_hi : cur_lo;
      n = $urandom_range(30, 70);
      repeat (n) begin
        case ($urandom_range(0, 5)) inside
          [0:1]: t = int'($urandom_range(0, 65535)) + TEMP_MIN;
          [2:3]: t = a + int'($urandom_range(0, b - a));
          4:     t = cur_lo + int'($urandom_range(0, 4)) - 2;
          default: t = cur_hi + int'($urandom_range(0, 4)) - 2;
        endcase
        send_temp(t);
        sent++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("thermal_pseudocolor_map_tb: PASS");
    end else begin
      $display("thermal_pseudocolor_map_tb: FAIL");
    end
    $finish;
  end

endmodule
